// ----- rtl/rent_pkg.sv -----
// rent_pkg: shared types and codes for the election node table
// no dependencies
package rent_pkg;

  localparam logic [2:0] OP_TIMEOUT  = 3'd0;
  localparam logic [2:0] OP_CAMPAIGN = 3'd1;
  localparam logic [2:0] OP_REQVOTE  = 3'd2;
  localparam logic [2:0] OP_VOTEREC  = 3'd3;
  localparam logic [2:0] OP_REPLY    = 3'd4;
  localparam logic [2:0] OP_APPEND   = 3'd5;

  localparam logic [2:0] K_TIMER    = 3'd0;
  localparam logic [2:0] K_CAMPAIGN = 3'd1;
  localparam logic [2:0] K_REQVOTE  = 3'd2;
  localparam logic [2:0] K_REPLY    = 3'd3;
  localparam logic [2:0] K_VOTEREC  = 3'd4;
  localparam logic [2:0] K_APPEND   = 3'd5;

  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;
  localparam logic [3:0] VOTE_NONE      = 4'd15;

  // what the controller asks of the datapath
  typedef struct packed {
    logic load;    // capture input and read node record
    logic decide;  // evaluate event, write record, latch plan
    logic emit;    // load output register with current result
  } cmd_t;

  // plan handed back to the controller
  typedef struct packed {
    logic       single;   // one or two fixed results
    logic       two;
    logic       bcast;    // broadcast to all other nodes
    logic       none;
  } stat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  dest;
    logic [2:0]  src;
    logic [31:0] term;
    logic [31:0] llt;
    logic [31:0] lli;
    logic        granted;
    logic        higher;
    logic [32:0] due;
    logic [15:0] interval;
    logic        elected;
  } res_t;

endpackage

// ----- rtl/rent_datapath.sv -----
// rent_datapath: per-node election records, event evaluation, result build
// depends on rent_pkg
module rent_datapath #(
  parameter int NODES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rent_pkg::cmd_t     cmd,
  input  logic [2:0]         slot,     // result slot or broadcast destination
  input  logic [3:0]         csize,
  input  logic [2:0]         in_op,
  input  logic [2:0]         in_node,
  input  logic [31:0]        in_event_time,
  input  logic [2:0]         in_peer,
  input  logic [31:0]        in_peer_term,
  input  logic signed [31:0] in_peer_last_term,
  input  logic signed [31:0] in_peer_last_index,
  input  logic               in_vote_granted,
  input  logic               in_term_update,
  input  logic [15:0]        in_timeout_interval,
  input  logic [15:0]        in_random_time,
  output rent_pkg::stat_t    stat,
  output logic [3:0]         active,
  output rent_pkg::res_t     res
);
  // the node field addresses at most eight records
  localparam int NEFF = (NODES > 8) ? 8 : NODES;
  localparam int NW = $clog2(NEFF);

  logic [1:0]  role_r   [NEFF];
  logic [31:0] term_r   [NEFF];
  logic [3:0]  vfor_r   [NEFF];
  logic [3:0]  vag_r    [NEFF];
  logic [3:0]  cast_r   [NEFF];
  logic [31:0] heard_r  [NEFF];

  logic [2:0]  op_r, nd_r, peer_r;
  logic [31:0] t_r, pterm_r;
  logic signed [31:0] plt_r, pli_r;
  logic        gr_r, upd_r;
  logic [15:0] ivl_r, rnd_r;
  logic        valid_nd_r;

  // outcome of evaluation, latched at decide
  rent_pkg::res_t r0_r, r1_r, rb_r;
  rent_pkg::res_t rb_d;
  rent_pkg::stat_t st_r;

  // effective cluster size
  logic [3:0] c;
  always_comb begin
    c = csize;
    if (c == 4'd0) c = 4'd1;
    if (c > 4'(NEFF)) c = 4'(NEFF);
    if (c > 4'd8) c = 4'd8;
  end
  assign active = c;

  logic [NW-1:0] ni;
  assign ni = nd_r[NW-1:0];

  logic [1:0]  role_n;
  logic [31:0] term_n;
  logic [3:0]  vf, va;
  logic [3:0]  cast_n;
  logic [31:0] heard_n;
  assign role_n  = role_r[ni];
  assign term_n  = term_r[ni];
  assign vf      = vfor_r[ni];
  assign va      = vag_r[ni];
  assign cast_n  = cast_r[ni];
  assign heard_n = heard_r[ni];

  logic [1:0]  role_x;
  logic [31:0] term_x, heard_x;
  logic [3:0]  vf_x, va_x, cast_x;
  rent_pkg::res_t a, b, bc;
  rent_pkg::stat_t st;
  logic signed [33:0] tdiff;
  logic [3:0] half;
  logic log_better;

  always_comb begin
    role_x = role_n; term_x = term_n; heard_x = heard_n;
    vf_x = vf; va_x = va; cast_x = cast_n;
    a = '0; b = '0; bc = '0; st = '0;
    half = c >> 1;
    tdiff = $signed({2'b00, t_r}) - $signed({18'd0, ivl_r});
    // empty log is -1/-1 on this node
    log_better = (-32'sd1 > plt_r) || ((plt_r == -32'sd1) && (-32'sd1 > pli_r));
    a.dest = nd_r; a.src = nd_r; a.due = {1'b0, t_r};
    b = a;
    bc.src = nd_r; bc.term = term_n; bc.llt = -32'sd1; bc.lli = -32'sd1;
    bc.due = {1'b0, t_r};
    st.none = 1'b1;
    if (valid_nd_r) begin
      case (op_r)
        rent_pkg::OP_TIMEOUT: begin
          if (tdiff >= $signed({2'b00, heard_n})) begin
            heard_x = t_r; cast_x = rent_pkg::VOTE_NONE; vf_x = '0; va_x = '0;
            a.kind = rent_pkg::K_TIMER; a.due = {1'b0, t_r} + 33'(rnd_r);
            a.interval = rnd_r;
            if (term_n != '1) term_x = term_n + 32'd1;
            role_x = rent_pkg::ROLE_CANDIDATE;
            b.kind = rent_pkg::K_CAMPAIGN;
            st = '0; st.two = 1'b1;
          end
        end
        rent_pkg::OP_CAMPAIGN: begin
          if (role_n == rent_pkg::ROLE_CANDIDATE) begin
            vf_x = 4'd1; cast_x = {1'b0, nd_r};
            bc.kind = rent_pkg::K_REQVOTE;
            st = '0; st.bcast = 1'b1;
          end
        end
        rent_pkg::OP_REQVOTE: begin
          a.kind = rent_pkg::K_REPLY; a.dest = peer_r; a.term = term_n;
          st = '0; st.single = 1'b1;
          if (term_n > pterm_r) begin
            a.higher = 1'b1;
          end else if (role_n == rent_pkg::ROLE_LEADER) begin
            if (term_n < pterm_r) begin
              role_x = rent_pkg::ROLE_FOLLOWER; a.granted = 1'b1;
            end
          end else if (cast_n != rent_pkg::VOTE_NONE || log_better) begin
            a.granted = 1'b0;
          end else begin
            heard_x = t_r;
            a = '0; a.kind = rent_pkg::K_TIMER; a.dest = nd_r; a.src = nd_r;
            a.due = {1'b0, t_r} + 33'(rnd_r); a.interval = rnd_r;
            b.kind = rent_pkg::K_VOTEREC; b.src = peer_r;
            st = '0; st.two = 1'b1;
          end
        end
        rent_pkg::OP_VOTEREC: begin
          cast_x = {1'b0, peer_r};
          a.kind = rent_pkg::K_REPLY; a.dest = peer_r; a.term = term_n;
          a.granted = 1'b1;
          st = '0; st.single = 1'b1;
        end
        rent_pkg::OP_REPLY: begin
          if (upd_r) begin
            term_x = pterm_r; role_x = rent_pkg::ROLE_FOLLOWER;
          end else if (role_n == rent_pkg::ROLE_CANDIDATE) begin
            if (gr_r) begin
              if (vf != 4'd15) vf_x = vf + 4'd1;
              if (vf_x > half) begin
                role_x = rent_pkg::ROLE_LEADER;
                bc.kind = rent_pkg::K_APPEND; bc.elected = 1'b1;
                st = '0; st.bcast = 1'b1;
              end
            end else begin
              if (va != 4'd15) va_x = va + 4'd1;
              if (va_x > half) begin
                heard_x = t_r;
                a.kind = rent_pkg::K_TIMER; a.interval = rnd_r;
                a.due = {1'b0, t_r} + {16'd0, rnd_r, 1'b0};
                st = '0; st.single = 1'b1;
              end
            end
          end
        end
        rent_pkg::OP_APPEND: begin
          if (pterm_r >= term_n) begin
            role_x = rent_pkg::ROLE_FOLLOWER; term_x = pterm_r;
            vf_x = '0; va_x = '0; cast_x = rent_pkg::VOTE_NONE;
          end
          heard_x = t_r;
        end
        default: ;
      endcase
    end
  end

  // broadcast result takes its destination from the slot
  always_comb begin
    rb_d = rb_r;
    rb_d.dest = slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NEFF; i++) begin
        role_r[i] <= rent_pkg::ROLE_FOLLOWER; term_r[i] <= '0;
        vfor_r[i] <= '0; vag_r[i] <= '0; cast_r[i] <= rent_pkg::VOTE_NONE;
        heard_r[i] <= '0;
      end
      st_r <= '0;
    end else begin
      if (cmd.decide) begin
        role_r[ni] <= role_x; term_r[ni] <= term_x; vfor_r[ni] <= vf_x;
        vag_r[ni] <= va_x; cast_r[ni] <= cast_x; heard_r[ni] <= heard_x;
        st_r <= st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; nd_r <= in_node; peer_r <= in_peer; t_r <= in_event_time;
      pterm_r <= in_peer_term; plt_r <= in_peer_last_term;
      pli_r <= in_peer_last_index; gr_r <= in_vote_granted;
      upd_r <= in_term_update; ivl_r <= in_timeout_interval;
      rnd_r <= in_random_time;
      valid_nd_r <= ({1'b0, in_node} < c);
    end
    if (cmd.decide) begin
      r0_r <= a; r1_r <= b; rb_r <= bc;
    end
    if (cmd.emit) begin
      if (st_r.bcast) res <= rb_d;
      else if (slot == 3'd0) res <= r0_r;
      else res <= r1_r;
    end
  end

  assign stat = st_r;
endmodule

// ----- rtl/rent_ctrl.sv -----
// rent_ctrl: sequencer for load, decide and result emission
// depends on rent_pkg
module rent_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_last,
  input  rent_pkg::stat_t stat,
  input  logic [3:0]      active,
  input  logic [2:0]      node,
  output rent_pkg::cmd_t  cmd,
  output logic [2:0]      slot
);
  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_PLAN, S_EMIT} state_t;
  state_t state_r;
  logic [3:0] idx_r;
  logic       oval_r, olast_r;
  logic [2:0] node_r;

  // next slot to emit, skipping own node during broadcast
  logic [3:0] cur, nxt;
  logic       have, more;
  always_comb begin
    cur = idx_r;
    if (stat.bcast && cur[2:0] == node_r && cur < active) cur = cur + 4'd1;
    have = stat.bcast ? (cur < active) : (stat.two ? cur < 4'd2 : cur < 4'd1);
    nxt = cur + 4'd1;
    if (stat.bcast && nxt[2:0] == node_r && nxt < active) nxt = nxt + 4'd1;
    more = stat.bcast ? (nxt < active) : (stat.two ? nxt < 4'd2 : 1'b0);
  end

  wire out_free = !oval_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = oval_r;
  assign out_last  = olast_r;
  assign slot      = cur[2:0];

  always_comb begin
    cmd = '0;
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.decide = (state_r == S_DECIDE);
    cmd.emit   = (state_r == S_EMIT) && out_free && have;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; idx_r <= '0; oval_r <= 1'b0; olast_r <= 1'b0;
      node_r <= '0;
    end else begin
      if (oval_r && !out_stall) oval_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          state_r <= S_DECIDE; node_r <= node;
        end
        S_DECIDE: state_r <= S_PLAN;
        S_PLAN: begin
          idx_r <= '0;
          state_r <= stat.none ? S_IDLE : S_EMIT;
        end
        S_EMIT: if (out_free) begin
          if (have) begin
            oval_r <= 1'b1; olast_r <= !more; idx_r <= nxt;
            if (!more) state_r <= S_IDLE;
          end else state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/raft_election_node_table.sv -----
// raft_election_node_table: top level of the election node table
// depends on rent_pkg, rent_ctrl, rent_datapath
//
// input channel in_*: one event per transfer, addressed to one node
// output channel out_*: the events it causes, out_last_item on the final one
// cfg_we/cfg_data: writes cluster_size (reset 3), to be done only while idle;
// the user is bound to this, as the block leaves it unchecked; an event is
// loaded, evaluated and planned over the single shared record port, then its
// results, up to seven for a broadcast, go one by one to the output register
// the input stalls until the last result is in the output register
// out_stall holds the output register and pauses emission
// reset (synchronous, rst_n low) puts every node to follower, term 0,
// no vote, counters zero, last heard 0
// events for nodes outside the cluster and unknown ops give no results
module raft_election_node_table #(
  parameter int NODES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [2:0]         in_node,
  input  logic [31:0]        in_event_time,
  input  logic [2:0]         in_peer,
  input  logic [31:0]        in_peer_term,
  input  logic signed [31:0] in_peer_last_term,
  input  logic signed [31:0] in_peer_last_index,
  input  logic               in_vote_granted,
  input  logic               in_term_update,
  input  logic [15:0]        in_timeout_interval,
  input  logic [15:0]        in_random_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic [2:0]         out_dest,
  output logic [2:0]         out_src,
  output logic [31:0]        out_term,
  output logic signed [31:0] out_last_log_term,
  output logic signed [31:0] out_last_log_index,
  output logic               out_granted,
  output logic               out_higher_term,
  output logic [32:0]        out_due_time,
  output logic [15:0]        out_interval,
  output logic               out_leader_elected,
  output logic               out_last_item
);
  logic [3:0] csize_r;
  rent_pkg::cmd_t  cmd;
  rent_pkg::stat_t stat;
  rent_pkg::res_t  res;
  logic [2:0] slot;
  logic [3:0] active;

  always_ff @(posedge clk) begin
    if (!rst_n) csize_r <= 4'd3;
    else if (cfg_we) csize_r <= cfg_data;
  end

  rent_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .out_last(out_last_item), .stat, .active, .node(in_node), .cmd, .slot
  );

  rent_datapath #(.NODES(NODES)) u_dp (
    .clk, .rst_n, .cmd, .slot, .csize(csize_r), .in_op, .in_node, .in_event_time,
    .in_peer, .in_peer_term, .in_peer_last_term, .in_peer_last_index,
    .in_vote_granted, .in_term_update, .in_timeout_interval, .in_random_time,
    .stat, .active, .res
  );

  assign out_kind           = res.kind;
  assign out_dest           = res.dest;
  assign out_src            = res.src;
  assign out_term           = res.term;
  assign out_last_log_term  = res.llt;
  assign out_last_log_index = res.lli;
  assign out_granted        = res.granted;
  assign out_higher_term    = res.higher;
  assign out_due_time       = res.due;
  assign out_interval       = res.interval;
  assign out_leader_elected = res.elected;

  // no new event while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_item) |-> in_stall) else $error("accept during burst");
  // only heartbeats carry the elected flag
  a_elect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_leader_elected) |-> (out_kind == rent_pkg::K_APPEND))
    else $error("elected flag on wrong kind");
  // a broadcast never addresses its sender
  a_self: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == rent_pkg::K_REQVOTE || out_kind == rent_pkg::K_APPEND))
    |-> (out_dest != out_src)) else $error("broadcast to self");
endmodule

// ----- tb/election_checker.sv -----
// election_checker: watches both channels of the election node table, predicts
// the events each accepted input causes and compares them in order
// depends on rent_pkg
module election_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [2:0]         in_node,
  input  logic [31:0]        in_event_time,
  input  logic [2:0]         in_peer,
  input  logic [31:0]        in_peer_term,
  input  logic signed [31:0] in_peer_last_term,
  input  logic signed [31:0] in_peer_last_index,
  input  logic               in_vote_granted,
  input  logic               in_term_update,
  input  logic [15:0]        in_timeout_interval,
  input  logic [15:0]        in_random_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_kind,
  input  logic [2:0]         out_dest,
  input  logic [2:0]         out_src,
  input  logic [31:0]        out_term,
  input  logic signed [31:0] out_last_log_term,
  input  logic signed [31:0] out_last_log_index,
  input  logic               out_granted,
  input  logic               out_higher_term,
  input  logic [32:0]        out_due_time,
  input  logic [15:0]        out_interval,
  input  logic               out_leader_elected,
  input  logic               out_last_item,
  output int                 fail_count,
  output int                 pending_events
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rent_pkg::res_t r;
    logic last;
  } emitted_t;

  emitted_t    event_q[$];
  emitted_t    batch[$];
  logic [3:0]  size_reg;
  logic [1:0]  role[8];
  logic [31:0] term_of[8];
  logic [3:0]  yes_cnt[8];
  logic [3:0]  no_cnt[8];
  logic [3:0]  voted[8];
  logic [31:0] heard[8];
  logic signed [31:0] log_t[8];
  logic signed [31:0] log_i[8];

  function automatic int unsigned active_count();
    int unsigned c;
    c = {28'd0, size_reg};
    if (c < 1) c = 1;
    if (c > 8) c = 8;
    return c;
  endfunction

  task automatic add(input logic [2:0] kind, input logic [2:0] dst, input logic [2:0] sr,
                     input logic [31:0] tm, input logic [31:0] lt, input logic [31:0] li,
                     input logic gr, input logic hi, input logic [32:0] due,
                     input logic [15:0] ivl, input logic el);
    emitted_t e;
    e.r = '{kind: kind, dest: dst, src: sr, term: tm, llt: lt, lli: li, granted: gr,
            higher: hi, due: due, interval: ivl, elected: el};
    e.last = 1'b0;
    batch = {batch, e};
  endtask

  task automatic predict_event();
    int unsigned c;
    logic [2:0]  nd;
    logic [32:0] t;
    logic [32:0] rnd;
    longint      early;
    c = active_count();
    nd = in_node;
    t = {1'b0, in_event_time};
    rnd = {17'd0, in_random_time};
    batch.delete();
    if (nd >= c) return;
    case (in_op)
      rent_pkg::OP_TIMEOUT: begin
        early = longint'(in_event_time) - longint'(in_timeout_interval);
        if (early >= longint'(heard[nd])) begin
          heard[nd] = in_event_time;
          voted[nd] = rent_pkg::VOTE_NONE;
          yes_cnt[nd] = '0;
          no_cnt[nd] = '0;
          add(rent_pkg::K_TIMER, nd, nd, '0, '0, '0, 1'b0, 1'b0, t + rnd,
              in_random_time, 1'b0);
          if (term_of[nd] != 32'hFFFF_FFFF) term_of[nd]++;
          role[nd] = rent_pkg::ROLE_CANDIDATE;
          add(rent_pkg::K_CAMPAIGN, nd, nd, '0, '0, '0, 1'b0, 1'b0, t, '0, 1'b0);
        end
      end
      rent_pkg::OP_CAMPAIGN: begin
        if (role[nd] == rent_pkg::ROLE_CANDIDATE) begin
          yes_cnt[nd] = 4'd1;
          voted[nd] = {1'b0, nd};
          for (int n = 0; n < c; n++)
            if (n != nd)
              add(rent_pkg::K_REQVOTE, 3'(n), nd, term_of[nd], log_t[nd], log_i[nd],
                  1'b0, 1'b0, t, '0, 1'b0);
        end
      end
      rent_pkg::OP_REQVOTE: begin
        if (term_of[nd] > in_peer_term)
          add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b0, 1'b1, t, '0, 1'b0);
        else if (role[nd] == rent_pkg::ROLE_LEADER) begin
          if (term_of[nd] < in_peer_term) begin
            role[nd] = rent_pkg::ROLE_FOLLOWER;
            add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b1, 1'b0, t, '0,
                1'b0);
          end else
            add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b0, 1'b0, t, '0,
                1'b0);
        end else if (voted[nd] != rent_pkg::VOTE_NONE)
          add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b0, 1'b0, t, '0, 1'b0);
        else if (log_t[nd] > in_peer_last_term ||
                 (log_t[nd] == in_peer_last_term && log_i[nd] > in_peer_last_index))
          add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b0, 1'b0, t, '0, 1'b0);
        else begin
          heard[nd] = in_event_time;
          add(rent_pkg::K_TIMER, nd, nd, '0, '0, '0, 1'b0, 1'b0, t + rnd,
              in_random_time, 1'b0);
          add(rent_pkg::K_VOTEREC, nd, in_peer, '0, '0, '0, 1'b0, 1'b0, t, '0, 1'b0);
        end
      end
      rent_pkg::OP_VOTEREC: begin
        voted[nd] = {1'b0, in_peer};
        add(rent_pkg::K_REPLY, in_peer, nd, term_of[nd], '0, '0, 1'b1, 1'b0, t, '0, 1'b0);
      end
      rent_pkg::OP_REPLY: begin
        if (in_term_update) begin
          term_of[nd] = in_peer_term;
          role[nd] = rent_pkg::ROLE_FOLLOWER;
        end else if (in_vote_granted) begin
          if (role[nd] == rent_pkg::ROLE_CANDIDATE) begin
            if (yes_cnt[nd] < 15) yes_cnt[nd]++;
            if (yes_cnt[nd] > c / 2) begin
              role[nd] = rent_pkg::ROLE_LEADER;
              for (int n = 0; n < c; n++)
                if (n != nd)
                  add(rent_pkg::K_APPEND, 3'(n), nd, term_of[nd], log_t[nd], log_i[nd],
                      1'b0, 1'b0, t, '0, 1'b1);
            end
          end
        end else if (role[nd] == rent_pkg::ROLE_CANDIDATE) begin
          if (no_cnt[nd] < 15) no_cnt[nd]++;
          if (no_cnt[nd] > c / 2) begin
            heard[nd] = in_event_time;
            add(rent_pkg::K_TIMER, nd, nd, '0, '0, '0, 1'b0, 1'b0, t + {rnd[31:0], 1'b0},
                in_random_time, 1'b0);
          end
        end
      end
      rent_pkg::OP_APPEND: begin
        if (in_peer_term >= term_of[nd]) begin
          role[nd] = rent_pkg::ROLE_FOLLOWER;
          term_of[nd] = in_peer_term;
          yes_cnt[nd] = '0;
          no_cnt[nd] = '0;
          voted[nd] = rent_pkg::VOTE_NONE;
        end
        heard[nd] = in_event_time;
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    event_q = {event_q, batch};
  endtask

  task automatic compare_event();
    emitted_t e;
    if (event_q.size() == 0) begin
      $error("unexpected output transfer kind=%0d dest=%0d", out_kind, out_dest);
      fail_count++;
      return;
    end
    e = event_q.pop_front();
    if (out_kind !== e.r.kind) begin
      $error("kind exp %0d got %0d", e.r.kind, out_kind); fail_count++; end
    if (out_dest !== e.r.dest) begin
      $error("dest exp %0d got %0d", e.r.dest, out_dest); fail_count++; end
    if (out_src !== e.r.src) begin
      $error("src exp %0d got %0d", e.r.src, out_src); fail_count++; end
    if (out_term !== e.r.term) begin
      $error("term exp %0h got %0h", e.r.term, out_term); fail_count++; end
    if (out_last_log_term !== e.r.llt) begin
      $error("last_log_term exp %0h got %0h", e.r.llt, out_last_log_term); fail_count++; end
    if (out_last_log_index !== e.r.lli) begin
      $error("last_log_index exp %0h got %0h", e.r.lli, out_last_log_index); fail_count++; end
    if (out_granted !== e.r.granted) begin
      $error("granted exp %0d got %0d", e.r.granted, out_granted); fail_count++; end
    if (out_higher_term !== e.r.higher) begin
      $error("higher_term exp %0d got %0d", e.r.higher, out_higher_term); fail_count++; end
    if (out_due_time !== e.r.due) begin
      $error("due_time exp %0h got %0h", e.r.due, out_due_time); fail_count++; end
    if (out_interval !== e.r.interval) begin
      $error("interval exp %0h got %0h", e.r.interval, out_interval); fail_count++; end
    if (out_leader_elected !== e.r.elected) begin
      $error("leader_elected exp %0d got %0d", e.r.elected, out_leader_elected);
      fail_count++;
    end
    if (out_last_item !== e.last) begin
      $error("last_item exp %0d got %0d", e.last, out_last_item); fail_count++; end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      size_reg = 4'd3;
      fail_count = 0;
      for (int i = 0; i < 8; i++) begin
        role[i] = rent_pkg::ROLE_FOLLOWER;
        term_of[i] = '0;
        yes_cnt[i] = '0;
        no_cnt[i] = '0;
        voted[i] = rent_pkg::VOTE_NONE;
        heard[i] = '0;
        log_t[i] = -1;
        log_i[i] = -1;
      end
      event_q.delete();
    end else begin
      if (cfg_we) size_reg = cfg_data;
      if (out_valid && !out_stall) compare_event();
      if (in_valid && !in_stall) predict_event();
    end
    pending_events = event_q.size();
  end
endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the election node table
// depends on rent_pkg, raft_election_node_table and election_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_op = '0, in_node = '0, in_peer = '0;
  logic [31:0] in_event_time = '0, in_peer_term = '0;
  logic signed [31:0] in_peer_last_term = '0, in_peer_last_index = '0;
  logic in_vote_granted = 1'b0, in_term_update = 1'b0;
  logic [15:0] in_timeout_interval = '0, in_random_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind, out_dest, out_src;
  logic [31:0] out_term;
  logic signed [31:0] out_last_log_term, out_last_log_index;
  logic out_granted, out_higher_term, out_leader_elected, out_last_item;
  logic [32:0] out_due_time;
  logic [15:0] out_interval;
  int fail_count, pending_events;
  int idle_cycles = 0;
  bit calm = 1'b0;
  logic [31:0] clock_now = 32'd100;
  logic [31:0] term_guess = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  raft_election_node_table dut (.*);
  election_checker checker_i (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic [2:0] op, input logic [2:0] nd, input logic [31:0] et,
                      input logic [2:0] pr, input logic [31:0] pt,
                      input logic [31:0] plt, input logic [31:0] pli,
                      input logic vg, input logic tu, input logic [15:0] ti,
                      input logic [15:0] rt);
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    in_op <= op; in_node <= nd; in_event_time <= et; in_peer <= pr;
    in_peer_term <= pt; in_peer_last_term <= plt; in_peer_last_index <= pli;
    in_vote_granted <= vg; in_term_update <= tu; in_timeout_interval <= ti;
    in_random_time <= rt;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_events != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_size(input logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed election traffic with random content
  task automatic random_event(input int unsigned c);
    logic [2:0] nd, pr, op;
    logic [31:0] pt;
    nd = 3'($urandom_range(0, c > 0 ? c - 1 : 0));
    pr = 3'($urandom_range(0, 7));
    if (pr >= c && $urandom_range(0, 3) != 0) pr = 3'($urandom_range(0, c - 1));
    clock_now = clock_now + $urandom_range(0, 3000);
    op = 3'($urandom_range(0, 5));
    pt = term_guess + $urandom_range(0, 3) - 1;
    if ($urandom_range(0, 15) == 0) pt = $urandom;
    if ($urandom_range(0, 20) == 0) begin
      op = 3'($urandom_range(6, 7));
      nd = 3'($urandom);
    end
    if ($urandom_range(0, 20) == 0) nd = 3'($urandom);
    if (op == rent_pkg::OP_TIMEOUT) term_guess = term_guess + 1;
    send(op, nd, ($urandom_range(0, 30) == 0) ? $urandom : clock_now, pr, pt,
         ($urandom_range(0, 3) == 0) ? $urandom : -1,
         ($urandom_range(0, 3) == 0) ? $urandom : -1,
         $urandom_range(0, 2) != 0, $urandom_range(0, 6) == 0,
         ($urandom_range(0, 8) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
         16'($urandom));
  endtask

  initial begin
    int unsigned c;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: full election on node 0 of three
    send(rent_pkg::OP_TIMEOUT, '0, 32'd1000, '0, '0, '0, '0, 1'b0, 1'b0, 16'd500, 16'hFFFF);
    send(rent_pkg::OP_CAMPAIGN, '0, 32'd1010, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_REQVOTE, 3'd1, 32'd1020, '0, 32'd1, -1, -1, 1'b0, 1'b0, '0, 16'd300);
    send(rent_pkg::OP_VOTEREC, 3'd1, 32'd1030, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_REPLY, '0, 32'd1040, 3'd1, 32'd1, '0, '0, 1'b1, 1'b0, '0, '0);
    send(rent_pkg::OP_REQVOTE, '0, 32'd1050, 3'd2, 32'd1, -1, -1, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_REQVOTE, '0, 32'd1060, 3'd2, 32'd5, -1, -1, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_REQVOTE, 3'd2, 32'd1070, 3'd1, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_APPEND, 3'd1, 32'd1080, '0, 32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_REQVOTE, 3'd1, 32'd1090, '0, 32'd2, -1, -1, 1'b0, 1'b0, '0, '0);
    // early timer and saturated term
    send(rent_pkg::OP_TIMEOUT, 3'd1, 32'd1100, '0, '0, '0, '0, 1'b0, 1'b0, 16'hFFFF, '0);
    send(rent_pkg::OP_TIMEOUT, 3'd1, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0, 1'b0, '0,
         16'hFFFF);
    send(rent_pkg::OP_CAMPAIGN, 3'd2, 32'd1200, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_TIMEOUT, 3'd2, 32'd90000, '0, '0, '0, '0, 1'b0, 1'b0, 16'd10, 16'd77);
    send(rent_pkg::OP_REPLY, 3'd2, 32'd90010, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'hFFFF);
    send(rent_pkg::OP_REPLY, 3'd2, 32'd90020, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'hFFFF);
    send(rent_pkg::OP_REPLY, 3'd2, 32'd90030, '0, '0, '0, '0, 1'b0, 1'b0, '0, 16'd5);
    send(rent_pkg::OP_REPLY, 3'd2, 32'd90040, '0, 32'hDEAD_BEEF, '0, '0, 1'b1, 1'b1, '0, '0);
    send(rent_pkg::OP_VOTEREC, 3'd2, 32'd90050, 3'd7, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(rent_pkg::OP_TIMEOUT, 3'd5, 32'd90060, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(3'd6, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    send(3'd7, 3'd1, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
    clock_now = 200000;
    // random phases across cluster sizes, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      logic [3:0] sz;
      case (ph)
        0: sz = 4'd8;
        1: sz = 4'd1;
        2: sz = 4'd0;
        3: sz = 4'd15;
        4: sz = 4'($urandom_range(2, 7));
        5: sz = 4'($urandom);
        default: sz = 4'd8;
      endcase
      set_size(sz);
      c = (sz == 4'd0) ? 1 : (sz > 4'd8 ? 8 : {28'd0, sz});
      if (ph == 6) calm = 1'b1;
      for (int k = 0; k < 64; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          // well-formed election round
          logic [2:0] nd;
          nd = 3'($urandom_range(0, c - 1));
          clock_now = clock_now + 70000;
          term_guess = term_guess + 1;
          send(rent_pkg::OP_TIMEOUT, nd, clock_now, '0, '0, '0, '0, 1'b0, 1'b0,
               16'($urandom_range(0, 100)), 16'($urandom));
          send(rent_pkg::OP_CAMPAIGN, nd, clock_now + 5, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
          repeat ($urandom_range(1, c)) send(rent_pkg::OP_REPLY, nd, clock_now + 9, '0, '0,
                                            '0, '0, $urandom_range(0, 3) != 0, 1'b0, '0,
                                            16'($urandom));
          k = k + 3;
        end else
          random_event(c);
      end
    end
    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
